FILE: hw/rtl/blpg_pkg.sv
// Shared constants and types for the line point generator.
`default_nettype none

package blpg_pkg;

  // Default coordinate width and the width of the point limit register.
  localparam int COORD_BITS_DEF = 13;
  localparam int MAX_POINTS_W   = 13;

  // Point limit after reset.
  localparam logic [MAX_POINTS_W-1:0] MAX_POINTS_RST = MAX_POINTS_W'(2048);

  // Operation carried by an input item.
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  // Flags prepared in the input stage for the line engine.
  typedef struct packed {
    logic is_start;
    logic dx_pos;
    logic dy_pos;
    logic steep;
  } item_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/blpg_channels.sv
// Valid/ready channel interfaces for the input items and the emitted points.
`default_nettype none

interface blpg_in_if #(
  parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;

  modport source (output valid, opcode, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface blpg_out_if #(
  parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/blpg_core.sv
// Line engine: line state, point limit register and the result register.
`default_nettype none

module blpg_core #(
  parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Prepared item from the input register
  input  logic                                 item_valid,
  input  blpg_pkg::item_flags_t                item_flags,
  input  logic [COORD_BITS-1:0]                item_x_start,
  input  logic [COORD_BITS-1:0]                item_y_start,
  input  logic [COORD_BITS-1:0]                item_x_end,
  input  logic [COORD_BITS-1:0]                item_y_end,
  input  logic [COORD_BITS:0]                  item_adx,
  input  logic [COORD_BITS:0]                  item_ady,
  output logic                                 item_take,
  // Point limit register write
  input  logic                                 cfg_wr_en,
  input  logic [blpg_pkg::MAX_POINTS_W-1:0]    cfg_wr_data,
  // Result register
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [COORD_BITS-1:0]                out_point_x,
  output logic [COORD_BITS-1:0]                out_point_y,
  output logic                                 out_last_point
);
  import blpg_pkg::*;

  localparam int DW    = COORD_BITS + 1;  // absolute delta
  localparam int INC_W = COORD_BITS + 2;  // straight increment
  localparam int ERR_W = COORD_BITS + 3;  // error term and diagonal increment

  localparam logic [COORD_BITS-1:0] STEP_UP   = COORD_BITS'(1);
  localparam logic [COORD_BITS-1:0] STEP_DOWN = '1;

  logic [MAX_POINTS_W-1:0] max_points_r;
  logic [COORD_BITS-1:0]   major_pos_r,  major_pos_nxt;
  logic [COORD_BITS-1:0]   minor_pos_r,  minor_pos_nxt;
  logic [COORD_BITS-1:0]   major_end_r,  major_end_nxt;
  logic [ERR_W-1:0]        error_term_r, error_term_nxt;
  logic [INC_W-1:0]        inc_straight_r, inc_straight_nxt;
  logic [ERR_W-1:0]        inc_diagonal_r, inc_diagonal_nxt;
  logic                    major_neg_r, major_neg_nxt;
  logic                    minor_neg_r, minor_neg_nxt;
  logic                    swapped_r, swapped_nxt;
  logic [MAX_POINTS_W-1:0] points_r, points_nxt;
  logic                    active_r, active_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0]   point_x_r, point_x_nxt;
  logic [COORD_BITS-1:0]   point_y_r, point_y_nxt;
  logic                    last_r, last_nxt;

  logic [DW-1:0]           dmaj, dmin;
  logic [INC_W-1:0]        dmin_minus_dmaj;
  logic                    end_hit;
  logic [ERR_W-1:0]        err_stepped;
  logic                    minor_moves;
  logic [COORD_BITS-1:0]   minor_stepped;
  logic [COORD_BITS-1:0]   major_stepped;
  logic [MAX_POINTS_W-1:0] points_inc;

  // The engine takes an item whenever the result register is free or being drained.
  assign item_take = item_valid && (!out_valid_r || out_ready);

  // Major and minor deltas for a start item.
  assign dmaj = item_flags.steep ? item_ady : item_adx;
  assign dmin = item_flags.steep ? item_adx : item_ady;
  assign dmin_minus_dmaj = {1'b0, dmin} - {1'b0, dmaj};

  // Step arithmetic on the registered line state.
  assign end_hit       = (major_pos_r == major_end_r) || (points_r >= max_points_r);
  assign minor_moves   = !error_term_r[ERR_W-1];
  assign err_stepped   = minor_moves ? (error_term_r + inc_diagonal_r)
                                     : (error_term_r + {1'b0, inc_straight_r});
  assign minor_stepped = minor_moves ? (minor_pos_r + (minor_neg_r ? STEP_DOWN : STEP_UP))
                                     : minor_pos_r;
  assign major_stepped = major_pos_r + (major_neg_r ? STEP_DOWN : STEP_UP);
  assign points_inc    = points_r + MAX_POINTS_W'(1);

  // Next state of the line and the result register.
  always_comb begin
    major_pos_nxt    = major_pos_r;
    minor_pos_nxt    = minor_pos_r;
    major_end_nxt    = major_end_r;
    error_term_nxt   = error_term_r;
    inc_straight_nxt = inc_straight_r;
    inc_diagonal_nxt = inc_diagonal_r;
    major_neg_nxt    = major_neg_r;
    minor_neg_nxt    = minor_neg_r;
    swapped_nxt      = swapped_r;
    points_nxt       = points_r;
    active_nxt       = active_r;
    point_x_nxt      = point_x_r;
    point_y_nxt      = point_y_r;
    last_nxt         = last_r;
    out_valid_nxt    = out_valid_r && !out_ready;

    if (item_take) begin
      if (item_flags.is_start) begin
        // Load a new line; nothing is emitted.
        swapped_nxt      = item_flags.steep;
        major_pos_nxt    = item_flags.steep ? item_y_start : item_x_start;
        major_end_nxt    = item_flags.steep ? item_y_end   : item_x_end;
        minor_pos_nxt    = item_flags.steep ? item_x_start : item_y_start;
        major_neg_nxt    = item_flags.steep ? !item_flags.dy_pos : !item_flags.dx_pos;
        minor_neg_nxt    = item_flags.steep ? !item_flags.dx_pos : !item_flags.dy_pos;
        inc_straight_nxt = {dmin, 1'b0};
        inc_diagonal_nxt = {dmin_minus_dmaj, 1'b0};
        error_term_nxt   = {1'b0, dmin, 1'b0} - {2'b00, dmaj};
        points_nxt       = '0;
        active_nxt       = 1'b1;
      end else if (active_r) begin
        if (end_hit) begin
          active_nxt = 1'b0;
        end else begin
          // Emit the current major position with the stepped minor position and advance along the major axis.
          error_term_nxt = err_stepped;
          minor_pos_nxt  = minor_stepped;
          major_pos_nxt  = major_stepped;
          points_nxt     = points_inc;
          point_x_nxt    = swapped_r ? minor_stepped : major_pos_r;
          point_y_nxt    = swapped_r ? major_pos_r : minor_stepped;
          last_nxt       = (major_stepped == major_end_r) || (points_inc >= max_points_r);
          out_valid_nxt  = 1'b1;
        end
      end
    end
  end

  // Control state and point limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_points_r   <= MAX_POINTS_RST;
      major_pos_r    <= '0;
      minor_pos_r    <= '0;
      major_end_r    <= '0;
      error_term_r   <= '0;
      inc_straight_r <= '0;
      inc_diagonal_r <= '0;
      major_neg_r    <= 1'b0;
      minor_neg_r    <= 1'b0;
      swapped_r      <= 1'b0;
      points_r       <= '0;
      active_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_points_r <= cfg_wr_data;
      end
      major_pos_r    <= major_pos_nxt;
      minor_pos_r    <= minor_pos_nxt;
      major_end_r    <= major_end_nxt;
      error_term_r   <= error_term_nxt;
      inc_straight_r <= inc_straight_nxt;
      inc_diagonal_r <= inc_diagonal_nxt;
      major_neg_r    <= major_neg_nxt;
      minor_neg_r    <= minor_neg_nxt;
      swapped_r      <= swapped_nxt;
      points_r       <= points_nxt;
      active_r       <= active_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    point_x_r <= point_x_nxt;
    point_y_r <= point_y_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = point_x_r;
  assign out_point_y    = point_y_r;
  assign out_last_point = last_r;

  // A step with no line loaded leaves the result register empty.
  a_no_line_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && !item_flags.is_start && !active_r |=> !out_valid_r)
    else $error("point emitted without an active line");

  // A start item arms a fresh line with a cleared point count.
  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item_flags.is_start |=> active_r && (points_r == '0))
    else $error("start item did not arm the line");

  // The minor axis moves by at most one position per emitted point.
  a_minor_unit_step: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && !item_flags.is_start && active_r && !end_hit |=>
      ((minor_pos_r - $past(minor_pos_r)) == '0) ||
      ((minor_pos_r - $past(minor_pos_r)) == STEP_UP) ||
      ((minor_pos_r - $past(minor_pos_r)) == STEP_DOWN))
    else $error("minor axis jumped by more than one");

endmodule

`default_nettype wire

FILE: hw/rtl/bresenham_line_point_generator_unit.sv
// Top level of the line point generator: input register and line engine.
//
// Usage:
//   in_chan carries items: a start item (opcode 0) loads both endpoints and
//   emits nothing; a step item (opcode 1) emits at most one point on out_chan.
//   A step emits the major position before its advance and the minor one after it; the end point is never emitted.
//   A line ends at its major end or after max_points points; the last point
//   carries last_point, and further steps give no point until the next start.
//   cfg_wr_en/cfg_wr_data write max_points; write it only between lines.
// Path: a step item passes the input register, which holds the prepared
//   deltas, and then the line engine, which loads the result register.
// Throughput: one item per cycle while the result register is free or being
//   drained; the line state is updated by combinational step arithmetic.
// Reset: no line is loaded, max_points returns to 2048, out_chan is empty.
// Stalls: in_chan keeps taking items while the result register holds a point
//   that the receiver has not yet taken, until the input register is also full;
//   it then holds ready low until out_chan.ready returns.
`default_nettype none

module bresenham_line_point_generator_unit #(
  parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  blpg_in_if.sink                           in_chan,
  blpg_out_if.source                        out_chan,
  input  logic                              cfg_wr_en,
  input  logic [blpg_pkg::MAX_POINTS_W-1:0] cfg_wr_data
);
  import blpg_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic                  in_valid_r;
  item_flags_t           flags_r, flags_nxt;
  logic [COORD_BITS-1:0] xs_r, ys_r, xe_r, ye_r;
  logic [DW-1:0]         adx_r, adx_nxt;
  logic [DW-1:0]         ady_r, ady_nxt;
  logic [DW-1:0]         dx, dy;
  logic                  item_take;

  // Signed deltas, one bit wider than the coordinates.
  assign dx = {in_chan.x_end[COORD_BITS-1], in_chan.x_end}
            - {in_chan.x_start[COORD_BITS-1], in_chan.x_start};
  assign dy = {in_chan.y_end[COORD_BITS-1], in_chan.y_end}
            - {in_chan.y_start[COORD_BITS-1], in_chan.y_start};

  // Absolute deltas, step directions and the steepness test.
  always_comb begin
    adx_nxt            = dx[DW-1] ? (~dx + DW'(1)) : dx;
    ady_nxt            = dy[DW-1] ? (~dy + DW'(1)) : dy;
    flags_nxt.is_start = (opcode_t'(in_chan.opcode) == OP_START);
    flags_nxt.dx_pos   = !dx[DW-1] && (dx != '0);
    flags_nxt.dy_pos   = !dy[DW-1] && (dy != '0);
    flags_nxt.steep    = adx_nxt < ady_nxt;
  end

  // The input register frees whenever the engine takes its item.
  assign in_chan.ready = !in_valid_r || item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  // Input payload registers capture on every transfer.
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      flags_r <= flags_nxt;
      xs_r    <= in_chan.x_start;
      ys_r    <= in_chan.y_start;
      xe_r    <= in_chan.x_end;
      ye_r    <= in_chan.y_end;
      adx_r   <= adx_nxt;
      ady_r   <= ady_nxt;
    end
  end

  // Line engine and result register.
  blpg_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (in_valid_r),
    .item_flags     (flags_r),
    .item_x_start   (xs_r),
    .item_y_start   (ys_r),
    .item_x_end     (xe_r),
    .item_y_end     (ye_r),
    .item_adx       (adx_r),
    .item_ady       (ady_r),
    .item_take      (item_take),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_point_x    (out_chan.point_x),
    .out_point_y    (out_chan.point_y),
    .out_last_point (out_chan.last_point)
  );

endmodule

`default_nettype wire
